// ===== hw/rtl/mtep_pkg.sv =====
// Shared types and constants for the MIDI track event parser.
`timescale 1ns / 1ps

package mtep_pkg;

    localparam logic [7:0] HI_BIT      = 8'h80;
    localparam logic [7:0] LOW7        = 8'h7f;
    localparam logic [7:0] NIBBLE_HI   = 8'hf0;
    localparam logic [7:0] META_STATUS = 8'hff;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_EOT    = 8'h2f;
    localparam logic [7:0] PROG_CHANGE = 8'hc0;
    localparam logic [7:0] CHAN_PRESS  = 8'hd0;

    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_TEMPO   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_OTHER   = 2'd3;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] delta_ticks;
        logic [31:0] tick_count;
        logic [7:0]  status_value;
        logic [7:0]  meta_kind;
        logic [7:0]  meta_len;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [7:0]  third_data;
    } t_event;

    // Program change and channel pressure carry a single data byte.
    function automatic logic takes_second(input logic [7:0] status);
        logic [7:0] hi;
        hi = status & NIBBLE_HI;
        return (hi != PROG_CHANGE) && (hi != CHAN_PRESS);
    endfunction

endpackage

// ===== hw/rtl/mtep_step.sv =====
// Byte-level parse state machine: consumes one track byte per request.
`timescale 1ns / 1ps

module mtep_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [7:0]         i_data_byte,
    input  logic               i_track_start,
    output logic               o_push,
    output mtep_pkg::t_event   o_event
);

    localparam logic [3:0] PH_DELTA     = 4'd0;
    localparam logic [3:0] PH_STATUS    = 4'd1;
    localparam logic [3:0] PH_DATA1     = 4'd2;
    localparam logic [3:0] PH_DATA2     = 4'd3;
    localparam logic [3:0] PH_META_TYPE = 4'd4;
    localparam logic [3:0] PH_META_LEN  = 4'd5;
    localparam logic [3:0] PH_TEMPO1    = 4'd6;
    localparam logic [3:0] PH_TEMPO2    = 4'd7;
    localparam logic [3:0] PH_TEMPO3    = 4'd8;

    logic [3:0]  r_phase,   n_phase;
    logic [7:0]  r_running, n_running;
    logic [31:0] r_delta,   n_delta;
    logic [31:0] r_ticks,   n_ticks;
    logic [7:0]  r_status,  n_status;
    logic [7:0]  r_mkind,   n_mkind;
    logic [7:0]  r_len,     n_len;
    logic [7:0]  r_first,   n_first;
    logic [7:0]  r_second,  n_second;

    // Values seen by this byte after an optional track restart.
    logic [3:0]  c_phase;
    logic [7:0]  c_running;
    logic [31:0] c_delta;
    logic [31:0] c_ticks;
    logic        c_emit;
    logic [1:0]  c_kind;
    logic [7:0]  c_ev_status, c_ev_mkind, c_ev_len, c_ev_d1, c_ev_d2, c_ev_d3;
    logic [7:0]  b;

    always_comb begin
        b         = i_data_byte;
        c_phase   = i_track_start ? PH_DELTA : r_phase;
        c_running = i_track_start ? 8'd0 : r_running;
        c_delta   = i_track_start ? 32'd0 : r_delta;
        c_ticks   = i_track_start ? 32'd0 : r_ticks;

        n_phase   = c_phase;
        n_running = c_running;
        n_delta   = c_delta;
        n_ticks   = c_ticks;
        n_status  = i_track_start ? 8'd0 : r_status;
        n_mkind   = i_track_start ? 8'd0 : r_mkind;
        n_len     = i_track_start ? 8'd0 : r_len;
        n_first   = i_track_start ? 8'd0 : r_first;
        n_second  = i_track_start ? 8'd0 : r_second;

        c_emit      = 1'b0;
        c_kind      = mtep_pkg::KIND_CHANNEL;
        c_ev_status = 8'd0;
        c_ev_mkind  = 8'd0;
        c_ev_len    = 8'd0;
        c_ev_d1     = 8'd0;
        c_ev_d2     = 8'd0;
        c_ev_d3     = 8'd0;

        unique case (c_phase)
            PH_STATUS: begin
                if (b == mtep_pkg::META_STATUS) begin
                    n_status = b;
                    n_phase  = PH_META_TYPE;
                end else if ((b & mtep_pkg::HI_BIT) != 8'd0) begin
                    n_status  = b;
                    n_running = b;
                    n_phase   = PH_DATA1;
                end else begin
                    // Running status: the byte is the first data byte.
                    n_status = c_running;
                    n_first  = b;
                    if (mtep_pkg::takes_second(c_running)) begin
                        n_phase = PH_DATA2;
                    end else begin
                        c_emit      = 1'b1;
                        c_ev_status = c_running;
                        c_ev_d1     = b;
                    end
                end
            end
            PH_DATA1: begin
                n_first = b;
                if (mtep_pkg::takes_second(r_status)) begin
                    n_phase = PH_DATA2;
                end else begin
                    c_emit      = 1'b1;
                    c_ev_status = r_status;
                    c_ev_d1     = b;
                end
            end
            PH_DATA2: begin
                c_emit      = 1'b1;
                c_ev_status = r_status;
                c_ev_d1     = r_first;
                c_ev_d2     = b;
            end
            PH_META_TYPE: begin
                n_mkind   = b;
                n_running = 8'd0;
                if (b == mtep_pkg::META_TEMPO || b == mtep_pkg::META_EOT) begin
                    n_phase = PH_META_LEN;
                end else begin
                    c_emit      = 1'b1;
                    c_kind      = mtep_pkg::KIND_OTHER;
                    c_ev_status = mtep_pkg::META_STATUS;
                    c_ev_mkind  = b;
                end
            end
            PH_META_LEN: begin
                n_len = b;
                if (r_mkind == mtep_pkg::META_EOT) begin
                    c_emit      = 1'b1;
                    c_kind      = mtep_pkg::KIND_END;
                    c_ev_status = mtep_pkg::META_STATUS;
                    c_ev_mkind  = mtep_pkg::META_EOT;
                    c_ev_len    = b;
                end else begin
                    n_phase = PH_TEMPO1;
                end
            end
            PH_TEMPO1: begin
                n_first = b;
                n_phase = PH_TEMPO2;
            end
            PH_TEMPO2: begin
                n_second = b;
                n_phase  = PH_TEMPO3;
            end
            PH_TEMPO3: begin
                c_emit      = 1'b1;
                c_kind      = mtep_pkg::KIND_TEMPO;
                c_ev_status = mtep_pkg::META_STATUS;
                c_ev_mkind  = mtep_pkg::META_TEMPO;
                c_ev_len    = r_len;
                c_ev_d1     = r_first;
                c_ev_d2     = r_second;
                c_ev_d3     = b;
            end
            default: begin
                // Delta byte; unused phase codes land here as well.
                n_delta = {c_delta[24:0], b[6:0]};
                if ((b & mtep_pkg::HI_BIT) != 8'd0) begin
                    n_phase = PH_DELTA;
                end else begin
                    n_ticks = c_ticks + {c_delta[24:0], b[6:0]};
                    n_phase = PH_STATUS;
                end
            end
        endcase

        if (c_emit) begin
            n_delta = 32'd0;
            n_phase = PH_DELTA;
        end
    end

    always_comb begin
        o_push               = i_take & c_emit;
        o_event.event_kind   = c_kind;
        o_event.delta_ticks  = c_delta;
        o_event.tick_count   = c_ticks;
        o_event.status_value = c_ev_status;
        o_event.meta_kind    = c_ev_mkind;
        o_event.meta_len     = c_ev_len;
        o_event.first_data   = c_ev_d1;
        o_event.second_data  = c_ev_d2;
        o_event.third_data   = c_ev_d3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DELTA;
            r_running <= 8'd0;
            r_delta   <= 32'd0;
            r_ticks   <= 32'd0;
            r_status  <= 8'd0;
            r_mkind   <= 8'd0;
            r_len     <= 8'd0;
            r_first   <= 8'd0;
            r_second  <= 8'd0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_running <= n_running;
            r_delta   <= n_delta;
            r_ticks   <= n_ticks;
            r_status  <= n_status;
            r_mkind   <= n_mkind;
            r_len     <= n_len;
            r_first   <= n_first;
            r_second  <= n_second;
        end
    end

endmodule

// ===== hw/rtl/mtep_out.sv =====
// Output register with one skid slot for parsed events.
`timescale 1ns / 1ps

module mtep_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mtep_pkg::t_event i_event,
    input  logic             i_stall,
    output logic             o_full,
    output logic             o_valid,
    output mtep_pkg::t_event o_event
);

    logic             r_out_valid;
    logic             r_skid_valid;
    mtep_pkg::t_event r_out;
    mtep_pkg::t_event r_skid;
    logic             out_take;

    assign out_take = r_out_valid & ~i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_event  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // No new events arrive while the skid slot is occupied.
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            if (i_push) begin
                r_out <= i_event;
            end
        end else if (i_push) begin
            r_skid <= i_event;
        end
    end

endmodule

// ===== hw/rtl/midi_track_event_parser_core.sv =====
// Top level of the MIDI track event parser.
`timescale 1ns / 1ps

// The parser takes a standard MIDI track one byte per request and reports each
// complete event: channel messages (with running status), tempo, end of track,
// and other meta events. Every byte is consumed in the cycle it is accepted, so
// a new byte can be taken on every clock while o_stall is low; a completed event
// is registered in the output register, or the skid slot if that is held. Each
// event carries its decoded variable-length delta and the running tick total,
// both wrapping at 32 bits. Raising i_track_start with a byte restarts the parse
// (phase, running status, tick total) before that byte, which is then read as
// the first delta byte. Results sit in an output register backed by one skid
// slot; the input stalls only while both hold events the downstream has not yet
// taken; a stalled output costs throughput only after two events are pending.

module midi_track_event_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_track_start,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_kind,
    output logic [31:0] o_delta_ticks,
    output logic [31:0] o_tick_count,
    output logic [7:0]  o_status_value,
    output logic [7:0]  o_meta_kind,
    output logic [7:0]  o_meta_len,
    output logic [7:0]  o_first_data,
    output logic [7:0]  o_second_data,
    output logic [7:0]  o_third_data
);

    logic             take;
    logic             push;
    logic             full;
    mtep_pkg::t_event step_event;
    mtep_pkg::t_event out_event;

    // A request is taken whenever the skid slot is free, so there is always
    // room for the event it may produce.
    assign o_stall = full;
    assign take    = i_valid & ~full;

    mtep_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_data_byte   (i_data_byte),
        .i_track_start (i_track_start),
        .o_push        (push),
        .o_event       (step_event)
    );

    mtep_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (step_event),
        .i_stall (i_stall),
        .o_full  (full),
        .o_valid (o_valid),
        .o_event (out_event)
    );

    assign o_event_kind   = out_event.event_kind;
    assign o_delta_ticks  = out_event.delta_ticks;
    assign o_tick_count   = out_event.tick_count;
    assign o_status_value = out_event.status_value;
    assign o_meta_kind    = out_event.meta_kind;
    assign o_meta_len     = out_event.meta_len;
    assign o_first_data   = out_event.first_data;
    assign o_second_data  = out_event.second_data;
    assign o_third_data   = out_event.third_data;

endmodule
